// ===== hw/rtl/jbt_pkg.sv =====
// ----------------------------------------------------------------------------
// jbt_pkg: shared types and codes for the JSON byte tokenizer
// Token kinds, error codes and the result record used by the tokenizer core.
// ----------------------------------------------------------------------------
package jbt_pkg;

  localparam int KindW = 5;
  localparam int ErrW  = 3;

  typedef enum logic [KindW-1:0] {
    KIND_LBRACE  = 5'd0,
    KIND_RBRACE  = 5'd1,
    KIND_LBRACK  = 5'd2,
    KIND_RBRACK  = 5'd3,
    KIND_COLON   = 5'd4,
    KIND_COMMA   = 5'd5,
    KIND_STRING  = 5'd6,
    KIND_INT     = 5'd7,
    KIND_FLOAT   = 5'd8,
    KIND_PERIOD  = 5'd9,
    KIND_TRUE    = 5'd10,
    KIND_FALSE   = 5'd11,
    KIND_NULL    = 5'd12,
    KIND_WORD    = 5'd13,
    KIND_END     = 5'd14,
    KIND_TEXT    = 5'd15,
    KIND_ERROR   = 5'd16
  } kind_t;

  typedef enum logic [ErrW-1:0] {
    ERR_NONE       = 3'd0,
    ERR_END_STR    = 3'd1,
    ERR_END_ESC    = 3'd2,
    ERR_BAD_ESC    = 3'd3,
    ERR_BAD_HEX    = 3'd4,
    ERR_BAD_NUMBER = 3'd5,
    ERR_OVERFLOW   = 3'd6
  } err_t;

  typedef struct packed {
    kind_t              kind;
    logic [7:0]         text_byte;
    logic signed [63:0] int_value;
    err_t               error_code;
  } res_t;

  function automatic res_t mk_res(kind_t k, logic [7:0] b, logic [63:0] v, err_t e);
    res_t r;
    r.kind       = k;
    r.text_byte  = b;
    r.int_value  = v;
    r.error_code = e;
    return r;
  endfunction

endpackage

// ===== hw/rtl/json_byte_tokenizer.sv =====
// Each accepted byte's results are registered into the result queue as the byte is taken.
// Throughput: one byte per cycle while output is ready and each byte yields at most one
// result; a byte that yields two or three results (word close, \u escape) holds the input
// until the four-entry result queue, draining one beat per ready cycle, is at most one deep.
// Input ready depends only on the registered queue count, never on output ready.
// Reset: synchronous, active high; clears the lexer state and empties the queue.
// ----------------------------------------------------------------------------
// json_byte_tokenizer: streaming JSON tokenizer, one byte per beat
// Single-pass lexer step from the lexer state and the input beat into a small
// result queue that feeds the output stream.
// ----------------------------------------------------------------------------
module json_byte_tokenizer
  import jbt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // end_of_document
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // [7:0] text_byte, [71:8] int_value, [74:72] error_code
  output logic [4:0]  m_tuser,   // [4:0] kind
  output logic        m_tlast    // last_of_item
);

  // Lexer modes. Number modes follow the grammar: sign, integer digits, dot,
  // fraction digits, exponent mark, exponent sign, exponent digits.
  typedef enum logic [3:0] {
    M_IDLE, M_STR, M_ESC, M_HEX, M_WORD, M_NSIGN, M_NINT, M_NDOT,
    M_NFRAC, M_NEXP, M_NEXPS, M_NEXPD, M_ERR
  } mode_t;

  localparam logic [3:0]  KmDead   = 4'd15;
  localparam logic [63:0] AccLimit = 64'd922337203685477580;

  // Keyword matcher: walks "true" (1..4), "false" (5..9), "null" (10..13).
  function automatic logic [7:0] km_char(logic [3:0] m);
    logic [7:0] r;
    unique case (m)
      4'd1: r = "r";  4'd2: r = "u";  4'd3: r = "e";
      4'd5: r = "a";  4'd6: r = "l";  4'd7: r = "s";  4'd8: r = "e";
      4'd10: r = "u"; 4'd11: r = "l"; 4'd12: r = "l";
      default: r = 8'd0;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] km_adv(logic [3:0] m, logic [7:0] c);
    logic [3:0] r;
    r = KmDead;
    if (m == 4'd0) begin
      if (c == "t") r = 4'd1;
      else if (c == "f") r = 4'd5;
      else if (c == "n") r = 4'd10;
    end else if (km_char(m) != 8'd0 && c == km_char(m)) begin
      r = m + 4'd1;
    end
    return r;
  endfunction

  function automatic kind_t km_kind(logic [3:0] m, kind_t fb);
    kind_t r;
    r = fb;
    if (m == 4'd4) r = KIND_TRUE;
    else if (m == 4'd9) r = KIND_FALSE;
    else if (m == 4'd13) r = KIND_NULL;
    return r;
  endfunction

  // Lexer state
  mode_t       mode, mode_next;
  logic [1:0]  hex_cnt, hex_cnt_next;
  logic [15:0] hex_val, hex_val_next;
  logic [63:0] mag, mag_next;
  logic        neg, neg_next;
  logic        frac, frac_next;
  logic        ovf, ovf_next;
  logic [3:0]  km, km_next;

  // Result queue: entry 0 is the output register. The fourth entry lets a new
  // byte land behind a stalled head beat.
  res_t       q [4];
  logic [3:0] q_last;
  logic [2:0] cnt;

  logic       in_fire, out_fire, keep_head;
  logic [7:0] c;
  logic       byte_ws, byte_dec;

  assign c        = s_tdata;
  assign byte_ws  = (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  assign byte_dec = (c >= "0") && (c <= "9");

  assign s_tready  = (cnt <= 3'd1);
  assign in_fire   = s_tvalid && s_tready;
  assign m_tvalid  = (cnt != 3'd0);
  assign out_fire  = m_tvalid && m_tready;
  assign keep_head = (cnt == 3'd1) && !m_tready;

  assign m_tdata = {5'd0, q[0].error_code, q[0].int_value, q[0].text_byte};
  assign m_tuser = q[0].kind;
  assign m_tlast = q_last[0];

  // What the byte does when the lexer is idle. This also serves the byte that
  // closes a word or a number, which is then handled as if idle.
  logic       idle_push, idle_num, idle_neg;
  res_t       idle_res;
  mode_t      idle_mode;
  logic [3:0] idle_km;

  always_comb begin
    idle_push = 1'b1;
    idle_num  = 1'b0;
    idle_neg  = (c == "-");
    idle_mode = M_IDLE;
    idle_km   = 4'd0;
    idle_res  = mk_res(KIND_TEXT, c, 64'd0, ERR_NONE);
    priority if (c == "{") idle_res.kind = KIND_LBRACE;
    else if (c == "}") idle_res.kind = KIND_RBRACE;
    else if (c == "[") idle_res.kind = KIND_LBRACK;
    else if (c == "]") idle_res.kind = KIND_RBRACK;
    else if (c == ":") idle_res.kind = KIND_COLON;
    else if (c == ",") idle_res.kind = KIND_COMMA;
    else if (c == ".") idle_res.kind = KIND_PERIOD;
    else if (c == "\"") begin
      idle_push = 1'b0;
      idle_mode = M_STR;
    end else if (byte_ws) begin
      idle_push = 1'b0;
    end else if (byte_dec || c == "-") begin
      idle_num  = 1'b1;
      idle_mode = idle_neg ? M_NSIGN : M_NINT;
    end else begin
      idle_mode = M_WORD;
      idle_km   = km_adv(4'd0, c);
    end
    if (idle_res.kind != KIND_TEXT) idle_res.text_byte = 8'd0;
  end

  // Closing a number with the current state.
  logic  close_err;
  res_t  close_res;
  always_comb begin
    close_err = 1'b0;
    close_res = mk_res(KIND_INT, 8'd0, neg ? (64'd0 - mag) : mag, ERR_NONE);
    if (mode == M_NSIGN || mode == M_NDOT || mode == M_NEXP || mode == M_NEXPS) begin
      close_err = 1'b1;
      close_res = mk_res(KIND_ERROR, 8'd0, 64'd0, ERR_BAD_NUMBER);
    end else if (frac) begin
      close_res = mk_res(KIND_FLOAT, 8'd0, 64'd0, ERR_NONE);
    end else if (ovf || (!neg && mag[63])) begin
      close_err = 1'b1;
      close_res = mk_res(KIND_ERROR, 8'd0, 64'd0, ERR_OVERFLOW);
    end
  end

  // Escape decode and hex digit value
  logic [8:0]  esc_d;
  logic [4:0]  nib;
  logic [15:0] hv;
  always_comb begin
    unique case (c)
      "\"":    esc_d = 9'h022;
      "\\":    esc_d = 9'h05c;
      "/":     esc_d = 9'h02f;
      "b":     esc_d = 9'd8;
      "f":     esc_d = 9'd12;
      "n":     esc_d = 9'd10;
      "r":     esc_d = 9'd13;
      "t":     esc_d = 9'd9;
      default: esc_d = 9'h100;
    endcase
    if (byte_dec) nib = {1'b0, c[3:0]};
    else if (c >= "a" && c <= "f") nib = 5'(c - "a" + 8'd10);
    else if (c >= "A" && c <= "F") nib = 5'(c - "A" + 8'd10);
    else nib = 5'd16;
    hv = {hex_val[11:0], nib[3:0]};
  end

  // Integer accumulation: magnitude times ten plus digit, by shifts and adds.
  logic [63:0] mag10;
  logic        acc_ovf;
  assign mag10   = (mag << 3) + (mag << 1) + {60'd0, c[3:0]};
  assign acc_ovf = (mag > AccLimit) || (mag == AccLimit && c[3:0] > 4'd8);

  // One lexer step: up to three results.
  res_t       res [3];
  logic [1:0] n;
  mode_t      nm;
  logic       nm_ok;
  logic [3:0] new_last;

  assign new_last = {1'b0, n == 2'd3, n == 2'd2, n == 2'd1};

  always_comb begin
    n            = 2'd0;
    res[0]       = mk_res(KIND_END, 8'd0, 64'd0, ERR_NONE);
    res[1]       = res[0];
    res[2]       = res[0];
    mode_next    = mode;
    hex_cnt_next = hex_cnt;
    hex_val_next = hex_val;
    mag_next     = mag;
    neg_next     = neg;
    frac_next    = frac;
    ovf_next     = ovf;
    km_next      = km;
    nm           = M_IDLE;
    nm_ok        = 1'b0;

    if (s_tlast) begin
      unique case (mode)
        M_STR: begin
          res[n] = mk_res(KIND_ERROR, 8'd0, 64'd0, ERR_END_STR); n = n + 2'd1;
        end
        M_ESC, M_HEX: begin
          res[n] = mk_res(KIND_ERROR, 8'd0, 64'd0, ERR_END_ESC); n = n + 2'd1;
        end
        M_WORD: begin
          res[n] = mk_res(km_kind(km, KIND_WORD), 8'd0, 64'd0, ERR_NONE); n = n + 2'd1;
        end
        M_NSIGN, M_NINT, M_NDOT, M_NFRAC, M_NEXP, M_NEXPS, M_NEXPD: begin
          res[n] = close_res; n = n + 2'd1;
        end
        default: ;
      endcase
      res[n]       = mk_res(KIND_END, 8'd0, 64'd0, ERR_NONE); n = n + 2'd1;
      mode_next    = M_IDLE;
      hex_cnt_next = 2'd0;
      hex_val_next = 16'd0;
      mag_next     = 64'd0;
      neg_next     = 1'b0;
      frac_next    = 1'b0;
      ovf_next     = 1'b0;
      km_next      = 4'd0;
    end else begin
      // Number grammar step
      unique case (mode)
        M_NSIGN, M_NINT: begin
          if (byte_dec) begin nm = M_NINT; nm_ok = 1'b1; end
          else if (mode == M_NINT && c == ".") begin nm = M_NDOT; nm_ok = 1'b1; end
          else if (mode == M_NINT && (c == "e" || c == "E")) begin
            nm = M_NEXP; nm_ok = 1'b1;
          end
        end
        M_NDOT, M_NFRAC: begin
          if (byte_dec) begin nm = M_NFRAC; nm_ok = 1'b1; end
          else if (mode == M_NFRAC && (c == "e" || c == "E")) begin
            nm = M_NEXP; nm_ok = 1'b1;
          end
        end
        M_NEXP: begin
          if (byte_dec) begin nm = M_NEXPD; nm_ok = 1'b1; end
          else if (c == "+" || c == "-") begin nm = M_NEXPS; nm_ok = 1'b1; end
        end
        M_NEXPS, M_NEXPD: begin
          if (byte_dec) begin nm = M_NEXPD; nm_ok = 1'b1; end
        end
        default: ;
      endcase

      unique case (mode)
        M_IDLE, M_WORD, M_NSIGN, M_NINT, M_NDOT, M_NFRAC, M_NEXP, M_NEXPS,
        M_NEXPD: begin
          if (mode != M_IDLE && mode != M_WORD && nm_ok) begin
            res[n]    = mk_res(KIND_TEXT, c, 64'd0, ERR_NONE); n = n + 2'd1;
            mode_next = nm;
            if (nm == M_NDOT || nm == M_NEXP) frac_next = 1'b1;
            if ((mode == M_NSIGN || mode == M_NINT) && byte_dec && !ovf) begin
              if (acc_ovf) ovf_next = 1'b1;
              else mag_next = mag10;
            end
          end else if (mode == M_WORD && !(byte_ws || c == "{" || c == "}" ||
                       c == "[" || c == "]" || c == "," || c == ":" || c == "\"")) begin
            res[n]  = mk_res(KIND_TEXT, c, 64'd0, ERR_NONE); n = n + 2'd1;
            km_next = km_adv(km, c);
          end else begin
            // Close the pending word or number, then treat the byte as idle.
            if (mode == M_WORD) begin
              res[n] = mk_res(km_kind(km, KIND_WORD), 8'd0, 64'd0, ERR_NONE);
              n = n + 2'd1;
            end else if (mode != M_IDLE) begin
              res[n] = close_res; n = n + 2'd1;
              mode_next = close_err ? M_ERR : M_IDLE;
            end
            if (mode == M_IDLE || mode == M_WORD || !close_err) begin
              if (idle_push) begin res[n] = idle_res; n = n + 2'd1; end
              mode_next = idle_mode;
              if (idle_mode == M_STR || idle_mode == M_WORD) km_next = idle_km;
              if (idle_num) begin
                neg_next  = idle_neg;
                frac_next = 1'b0;
                ovf_next  = 1'b0;
                mag_next  = idle_neg ? 64'd0 : {60'd0, c[3:0]};
              end
            end
          end
        end
        M_STR: begin
          if (c == "\"") begin
            mode_next = M_IDLE;
            res[n] = mk_res(km_kind(km, KIND_STRING), 8'd0, 64'd0, ERR_NONE); n = n + 2'd1;
          end else if (c == "\\") begin
            mode_next = M_ESC;
          end else begin
            res[n]  = mk_res(KIND_TEXT, c, 64'd0, ERR_NONE); n = n + 2'd1;
            km_next = km_adv(km, c);
          end
        end
        M_ESC: begin
          if (c == "u") begin
            mode_next    = M_HEX;
            hex_cnt_next = 2'd0;
            hex_val_next = 16'd0;
          end else if (!esc_d[8]) begin
            mode_next = M_STR;
            res[n]    = mk_res(KIND_TEXT, esc_d[7:0], 64'd0, ERR_NONE); n = n + 2'd1;
            km_next   = km_adv(km, esc_d[7:0]);
          end else begin
            mode_next = M_ERR;
            res[n] = mk_res(KIND_ERROR, 8'd0, 64'd0, ERR_BAD_ESC); n = n + 2'd1;
          end
        end
        M_HEX: begin
          if (nib[4]) begin
            mode_next = M_ERR;
            res[n] = mk_res(KIND_ERROR, 8'd0, 64'd0, ERR_BAD_HEX); n = n + 2'd1;
          end else begin
            hex_val_next = hv;
            if (hex_cnt != 2'd3) begin
              hex_cnt_next = hex_cnt + 2'd1;
            end else begin
              hex_cnt_next = 2'd0;
              mode_next    = M_STR;
              // Any byte at or above 0x80 kills a keyword match.
              if (hv <= 16'd127) begin
                res[0]  = mk_res(KIND_TEXT, hv[7:0], 64'd0, ERR_NONE);
                n       = 2'd1;
                km_next = km_adv(km, hv[7:0]);
              end else if (hv <= 16'd2047) begin
                res[0]  = mk_res(KIND_TEXT, 8'hc0 | 8'(hv >> 6), 64'd0, ERR_NONE);
                res[1]  = mk_res(KIND_TEXT, 8'h80 | {2'b0, hv[5:0]}, 64'd0, ERR_NONE);
                n       = 2'd2;
                km_next = KmDead;
              end else begin
                res[0]  = mk_res(KIND_TEXT, 8'he0 | {4'b0, hv[15:12]}, 64'd0, ERR_NONE);
                res[1]  = mk_res(KIND_TEXT, 8'h80 | {2'b0, hv[11:6]}, 64'd0, ERR_NONE);
                res[2]  = mk_res(KIND_TEXT, 8'h80 | {2'b0, hv[5:0]}, 64'd0, ERR_NONE);
                n       = 2'd3;
                km_next = KmDead;
              end
            end
          end
        end
        default: ;  // sticky error: data bytes are dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= M_IDLE;
      hex_cnt <= 2'd0;
      hex_val <= 16'd0;
      mag     <= 64'd0;
      neg     <= 1'b0;
      frac    <= 1'b0;
      ovf     <= 1'b0;
      km      <= 4'd0;
      cnt     <= 3'd0;
      q_last  <= 4'd0;
    end else begin
      if (in_fire) begin
        mode    <= mode_next;
        hex_cnt <= hex_cnt_next;
        hex_val <= hex_val_next;
        mag     <= mag_next;
        neg     <= neg_next;
        frac    <= frac_next;
        ovf     <= ovf_next;
        km      <= km_next;
      end
      // A new byte behind a stalled head beat lands after it.
      if (in_fire && keep_head) begin
        cnt    <= 3'd1 + {1'b0, n};
        q_last <= {new_last[2:0], q_last[0]};
      end else if (in_fire) begin
        cnt    <= {1'b0, n};
        q_last <= new_last;
      end else if (out_fire) begin
        cnt    <= cnt - 3'd1;
        q_last <= {1'b0, q_last[3:1]};
      end
    end
  end

  // Queue payload needs no reset.
  always_ff @(posedge clk) begin
    if (in_fire && keep_head) begin
      q[1] <= res[0];
      q[2] <= res[1];
      q[3] <= res[2];
    end else if (in_fire) begin
      q[0] <= res[0];
      q[1] <= res[1];
      q[2] <= res[2];
    end else if (out_fire) begin
      q[0] <= q[1];
      q[1] <= q[2];
      q[2] <= q[3];
    end
  end

endmodule

// ===== hw/rtl/jbt_checker.sv =====
// ----------------------------------------------------------------------------
// jbt_checker: port-level checks for the JSON byte tokenizer
// Watches the output stream of the tokenizer; bound into the tokenizer module.
// ----------------------------------------------------------------------------
module jbt_checker
  import jbt_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [79:0] m_tdata,
  input logic [4:0]  m_tuser,
  input logic        m_tlast
);

  // A stalled beat holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("output beat changed while stalled");

  // Error codes appear only on error beats.
  a_err: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != KIND_ERROR |-> m_tdata[74:72] == ERR_NONE)
    else $error("error code on a non-error beat");

  // An end beat always closes the results of its item.
  a_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_END |-> m_tlast)
    else $error("end beat without last marker");

  // Nothing comes out right after reset.
  a_rst: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("output valid right after reset");

endmodule

bind json_byte_tokenizer jbt_checker u_jbt_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
